/* rtl/core/bounded_vector_list_engine_top_defines.svh */
// assertion macros for the bounded vector list engine
// used by bounded_vector_list_engine_top, expects clk and rst in scope
`ifndef BOUNDED_VECTOR_LIST_ENGINE_TOP_DEFINES_SVH
`define BOUNDED_VECTOR_LIST_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BVLE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bvle same-cycle check failed");

// next-cycle implication, checked outside reset
`define BVLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bvle next-cycle check failed");

`endif

/* rtl/core/bvle_pkg.sv */
// shared types and defaults for the bounded vector list engine
// no dependencies
`default_nettype none

package bvle_pkg;

  localparam int DEPTH_DEF        = 64;
  localparam int ELEMENT_BITS_DEF = 32;
  localparam int OP_W             = 3;
  localparam int DATA_W           = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_REPLACE = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_READ    = 3'd4,
    OP_CLEAR   = 3'd5
  } op_t;

  // broadcast to every cell for one beat
  typedef struct packed {
    logic load;   // cell at addr takes wr_data
    logic shift;  // cells at or above addr take their right neighbor
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/bvle_cell.sv */
// one storage cell of the list: holds a single element
// depends on bvle_pkg for the broadcast control struct
`default_nettype none

module bvle_cell import bvle_pkg::*; #(
  parameter int ELEM_W = ELEMENT_BITS_DEF,
  parameter int POS_W  = 6,
  parameter int IDX    = 0
) (
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [POS_W-1:0]  addr,
  input  wire logic [ELEM_W-1:0] wr_data,
  input  wire logic [ELEM_W-1:0] nbr_data,
  output logic      [ELEM_W-1:0] value,
  output logic      [ELEM_W-1:0] rd_term
);

  logic [ELEM_W-1:0] value_next;
  logic              hit;
  logic              at_or_above;

  assign hit         = (addr == POS_W'(IDX));
  assign at_or_above = (POS_W'(IDX) >= addr);

  always_comb begin
    value_next = value;
    if (ctrl.load && hit) begin
      value_next = wr_data;
    end else if (ctrl.shift && at_or_above) begin
      value_next = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // and-or read bus term
  assign rd_term = hit ? value : '0;

endmodule

`default_nettype wire

/* rtl/core/bounded_vector_list_engine_top.sv */
// channel | dir | signals                               | beat when
// in      | in  | op, position, element_data            | in_valid & in_ready
// out     | out | ok, read_data, count, is_empty        | out_valid & out_ready
// cfg     | in  | max_entries                           | cfg_valid & cfg_ready
//
// an accepted beat updates every cell and the count at the same edge and loads
// the result register, so a new beat can enter each cycle while out_ready is
// high. remove shifts all later cells left at that same edge.
// read goes through an and-or bus across the row of cells.
// in_ready drops only while a result waits and out_ready is low.
// synchronous reset clears the count and the result valid; max_entries resets
// to DEPTH. cfg is always ready.
//
// depends on bvle_pkg, bvle_cell and bounded_vector_list_engine_top_defines.svh
`default_nettype none

`include "bounded_vector_list_engine_top_defines.svh"

module bounded_vector_list_engine_top import bvle_pkg::*; #(
  parameter  int DEPTH        = DEPTH_DEF,
  parameter  int ELEMENT_BITS = ELEMENT_BITS_DEF,
  localparam int POS_W        = $clog2(DEPTH),
  localparam int CNT_W        = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,

  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   op,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [DATA_W-1:0] element_data,

  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   ok,
  output logic      [DATA_W-1:0] read_data,
  output logic      [CNT_W-1:0]  count,
  output logic                   is_empty,

  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CNT_W-1:0]  max_entries
);

  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_next;
  logic [CNT_W-1:0]        max_cfg;
  logic [CNT_W-1:0]        limit;
  logic                    fire;
  logic                    in_range;
  logic                    ok_next;
  logic [DATA_W-1:0]       rd_next;
  logic [POS_W-1:0]        addr;
  cell_ctrl_t              ctrl_raw;
  cell_ctrl_t              cell_ctrl;
  logic [ELEMENT_BITS-1:0] wr_elem;
  logic [ELEMENT_BITS-1:0] rd_bus;
  logic [ELEMENT_BITS-1:0] cell_val [DEPTH];
  logic [ELEMENT_BITS-1:0] rd_terms [DEPTH];

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign fire      = in_valid && in_ready;

  // a limit above the cell count behaves as the cell count
  assign limit    = (max_cfg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : max_cfg;
  assign in_range = (CNT_W'(position) < cnt);
  assign wr_elem  = ELEMENT_BITS'(element_data);

  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | rd_terms[i];
    end
  end

  always_comb begin
    ok_next        = 1'b0;
    rd_next        = '0;
    cnt_next       = cnt;
    addr           = position;
    ctrl_raw.load  = 1'b0;
    ctrl_raw.shift = 1'b0;
    unique case (op_t'(op))
      OP_PUSH: begin
        addr = cnt[POS_W-1:0];
        if (cnt < limit) begin
          ctrl_raw.load = 1'b1;
          cnt_next      = cnt + CNT_W'(1);
          ok_next       = 1'b1;
        end
      end
      OP_POP: begin
        if (cnt != '0) begin
          cnt_next = cnt - CNT_W'(1);
          ok_next  = 1'b1;
        end
      end
      OP_REPLACE: begin
        if (in_range) begin
          ctrl_raw.load = 1'b1;
          ok_next       = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (in_range) begin
          ctrl_raw.shift = 1'b1;
          cnt_next       = cnt - CNT_W'(1);
          ok_next        = 1'b1;
        end
      end
      OP_READ: begin
        if (in_range) begin
          rd_next = DATA_W'(rd_bus);
          ok_next = 1'b1;
        end
      end
      OP_CLEAR: begin
        cnt_next = '0;
        ok_next  = 1'b1;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  assign cell_ctrl.load  = ctrl_raw.load && fire;
  assign cell_ctrl.shift = ctrl_raw.shift && fire;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ELEMENT_BITS-1:0] nbr;
    if (g == DEPTH - 1) begin : g_last
      assign nbr = cell_val[g];
    end else begin : g_mid
      assign nbr = cell_val[g+1];
    end
    bvle_cell #(
      .ELEM_W (ELEMENT_BITS),
      .POS_W  (POS_W),
      .IDX    (g)
    ) u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .addr     (addr),
      .wr_data  (wr_elem),
      .nbr_data (nbr),
      .value    (cell_val[g]),
      .rd_term  (rd_terms[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      max_cfg   <= CNT_W'(DEPTH);
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_cfg <= max_entries;
      end
      if (fire) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      ok        <= ok_next;
      read_data <= rd_next;
      count     <= cnt_next;
      is_empty  <= (cnt_next == '0);
    end
  end

  `BVLE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt <= CNT_W'(DEPTH))
  `BVLE_ASSERT_IMP(a_rd_zero_on_refuse, out_valid && !ok, read_data == '0)
  `BVLE_ASSERT_NEXT(a_push_grows, fire && ok_next && (op == OP_PUSH), cnt == $past(cnt) + 1'b1)
  `BVLE_ASSERT_NEXT(a_count_tracks, fire, (count == cnt) && (is_empty == (cnt == '0)))

endmodule

`default_nettype wire

/* sim/bounded_vector_list_engine_top_tb.sv */
// self-checking testbench for bounded_vector_list_engine_top: list commands are
// checked against a shadow copy of the list, under several max_entries settings
// depends on bvle_pkg and the rtl of bounded_vector_list_engine_top
`default_nettype none

module bounded_vector_list_engine_top_tb;
  import bvle_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEF;
  localparam int POS_W       = $clog2(DEPTH_DEF);
  localparam int CNT_W       = $clog2(DEPTH_DEF + 1);
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 96;
  localparam int NUM_PHASES  = 12;
  localparam int HOLD_AFTER  = 350;
  localparam int HOLD_CYCLES = 300;

  // op codes the block has no meaning for
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] data;
  } list_cmd_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
  } list_result_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   op           = '0;
  logic [POS_W-1:0]  position     = '0;
  logic [DATA_W-1:0] element_data = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic              ok;
  logic [DATA_W-1:0] read_data;
  logic [CNT_W-1:0]  count;
  logic              is_empty;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  max_entries  = '0;

  bounded_vector_list_engine_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .position     (position),
    .element_data (element_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ok           (ok),
    .read_data    (read_data),
    .count        (count),
    .is_empty     (is_empty),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .max_entries  (max_entries)
  );

  always #5 clk = ~clk;

  // shadow list
  logic [DATA_W-1:0] shadow_entries [LIST_DEPTH];
  int unsigned       shadow_count = 0;
  int unsigned       shadow_limit = LIST_DEPTH;

  list_cmd_t    pending_cmds [$];
  list_result_t expected_results [$];
  list_cmd_t    cur_cmd;
  bit           cmd_loaded   = 1'b0;
  bit           steady_flow  = 1'b0;
  int           send_gap     = 0;
  int           ready_gap    = 0;
  int           hold_left    = 0;
  int           fail_count   = 0;
  int           items_taken  = 0;
  int           results_seen = 0;
  int           refused_ops  = 0;
  int           good_reads   = 0;
  int           peak_count   = 0;
  int           limit_writes = 0;
  int           cycle_count  = 0;

  function automatic list_result_t apply_list_op(input list_cmd_t c);
    list_result_t r;
    int unsigned  lim;
    int unsigned  i;
    r   = '0;
    lim = (shadow_limit > LIST_DEPTH) ? LIST_DEPTH : shadow_limit;
    unique case (c.op)
      OP_PUSH: begin
        if (shadow_count < lim) begin
          shadow_entries[shadow_count] = c.data;
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (shadow_count > 0) begin
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      OP_REPLACE: begin
        if (c.position < shadow_count) begin
          shadow_entries[c.position] = c.data;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (c.position < shadow_count) begin
          // close the gap left by the removed element
          for (i = c.position; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i + 1];
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (c.position < shadow_count) begin
          r.read_data = shadow_entries[c.position];
          r.ok        = 1'b1;
          good_reads++;
        end
      end
      OP_CLEAR: begin
        shadow_count = 0;
        r.ok         = 1'b1;
      end
      default: ;
    endcase
    if (!r.ok) refused_ops++;
    if (shadow_count > peak_count) peak_count = shadow_count;
    r.count    = shadow_count[CNT_W-1:0];
    r.is_empty = (shadow_count == 0);
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic list_cmd_t gen_cmd(input mix_t mix, input int span);
    list_cmd_t c;
    int        r;
    int        cut [6];
    unique case (mix)
      MIX_FILL:  cut = '{55, 62, 72, 78, 95, 96};
      MIX_CHURN: cut = '{28, 40, 55, 68, 94, 96};
      default:   cut = '{12, 35, 45, 70, 96, 97};
    endcase
    r = $urandom_range(0, 99);
    if (r < cut[0])      c.op = OP_PUSH;
    else if (r < cut[1]) c.op = OP_POP;
    else if (r < cut[2]) c.op = OP_REPLACE;
    else if (r < cut[3]) c.op = OP_REMOVE;
    else if (r < cut[4]) c.op = OP_READ;
    else if (r < cut[5]) c.op = OP_CLEAR;
    else                 c.op = $urandom_range(0, 1) ? OP_RSVD7 : OP_RSVD6;
    if ($urandom_range(0, 3) == 0)
      c.position = POS_W'($urandom_range(0, LIST_DEPTH - 1));
    else
      c.position = POS_W'($urandom_range(0, span - 1));
    r = $urandom_range(0, 15);
    if (r == 0)      c.data = '0;
    else if (r == 1) c.data = '1;
    else             c.data = $urandom();
    return c;
  endfunction

  task automatic queue_cmd(input logic [OP_W-1:0] o, input int p, input logic [DATA_W-1:0] d);
    list_cmd_t c;
    c.op       = o;
    c.position = p[POS_W-1:0];
    c.data     = d;
    pending_cmds.push_back(c);
  endtask

  // every queued command accepted and every result checked
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || cmd_loaded || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] v);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_valid   <= 1'b1;
    max_entries <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    shadow_limit = v;
    limit_writes++;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                             input logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      cmd_loaded = 1'b0;
      send_gap   = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_list_op(cur_cmd));
        cmd_loaded = 1'b0;
        items_taken++;
      end
      if (!cmd_loaded) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd      = pending_cmds.pop_front();
          cmd_loaded   = 1'b1;
          send_gap     = idle_len();
          op           <= cur_cmd.op;
          position     <= cur_cmd.position;
          element_data <= cur_cmd.data;
        end
      end
      in_valid <= cmd_loaded;
    end
  end

  // result monitor
  always @(posedge clk) begin
    list_result_t exp_r;
    bit           rdy;
    if (rst) begin
      out_ready <= 1'b0;
      ready_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no command outstanding");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("ok", exp_r.ok, ok);
          check_field("read_data", exp_r.read_data, read_data);
          check_field("count", exp_r.count, count);
          check_field("is_empty", exp_r.is_empty, is_empty);
        end
        results_seen++;
        // one long hold-off so the block backs up onto its input
        if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        rdy = 1'b0;
      end else begin
        rdy       = 1'b1;
        ready_gap = idle_len();
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [CNT_W-1:0] phase_limit [NUM_PHASES];
    mix_t             phase_mix [NUM_PHASES];
    int               span;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;
    phase_limit = '{7'd1, 7'd0, 7'd127, 7'd10, 7'd64, 7'd65, 7'd2, 7'd100,
                    7'd0, 7'd0, 7'd0, 7'd64};
    phase_mix   = '{MIX_FILL, MIX_CHURN, MIX_FILL, MIX_CHURN, MIX_CHURN, MIX_FILL,
                    MIX_CHURN, MIX_FILL, MIX_CHURN, MIX_DRAIN, MIX_CHURN, MIX_DRAIN};
    for (int i = 8; i < 11; i++) phase_limit[i] = CNT_W'($urandom_range(0, 127));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty list: everything indexed is refused, clear still succeeds; then reads, replaces and removes on a short list
    queue_cmd(OP_READ, 0, '0);
    queue_cmd(OP_POP, 0, '0);
    queue_cmd(OP_REMOVE, 0, '0);
    queue_cmd(OP_REPLACE, 0, 32'h1234_5678);
    queue_cmd(OP_CLEAR, 0, '0);
    queue_cmd(OP_RSVD6, 0, '1);
    queue_cmd(OP_RSVD7, 63, '1);
    queue_cmd(OP_PUSH, 63, 32'h0000_0000);
    queue_cmd(OP_PUSH, 0, 32'hFFFF_FFFF);
    queue_cmd(OP_PUSH, 0, 32'hA5A5_A5A5);
    queue_cmd(OP_READ, 0, '1);
    queue_cmd(OP_READ, 1, '0);
    queue_cmd(OP_READ, 2, '0);
    queue_cmd(OP_READ, 3, '0);
    queue_cmd(OP_REPLACE, 1, 32'h5A5A_5A5A);
    queue_cmd(OP_REPLACE, 3, 32'hDEAD_BEEF);
    queue_cmd(OP_REMOVE, 0, '0);
    queue_cmd(OP_READ, 0, '0);
    queue_cmd(OP_READ, 1, '0);
    queue_cmd(OP_REMOVE, 1, '0);
    queue_cmd(OP_READ, 63, '0);
    queue_cmd(OP_POP, 0, '0);
    queue_cmd(OP_CLEAR, 0, '0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_limit(phase_limit[ph]);
      steady_flow = (ph % 4 == 3);
      span = (shadow_limit == 0 || shadow_limit > LIST_DEPTH) ? LIST_DEPTH : shadow_limit;
      for (int n = 0; n < PHASE_ITEMS; n++)
        pending_cmds.push_back(gen_cmd(phase_mix[ph], span));
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("%0d commands and %0d results over %0d limit writes",
             items_taken, results_seen, limit_writes);
    $display("%0d refused, %0d successful reads, list peaked at %0d entries",
             refused_ops, good_reads, peak_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
